@@ src/owd_pkg.sv @@
package owd_pkg;

    // default table depth
    localparam int MAX_PEERS_DEF = 64;

    // field widths
    localparam int PEER_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int DELAY_W    = 32;
    localparam int HALF_W     = 31;
    localparam int HEAD_W     = 16;
    localparam int TIME_W     = 48;
    localparam int VALUE_W    = 49;
    localparam int MASK_W     = 64;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // blend numerator width: 7*old + 3*half stays below 10 * 2^32
    localparam int DIVIDEND_W = 36;

    // register reset values
    localparam logic [PEER_W-1:0]  LOCAL_PEER_RST    = '0;
    localparam logic [COUNT_W-1:0] PEER_COUNT_RST    = 7'd1;
    localparam logic [DELAY_W-1:0] DEFAULT_DELAY_RST = 32'd50;
    localparam logic [HEAD_W-1:0]  HEADROOM_RST      = 16'd10;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_PEER    = 2'd0,
        CFG_PEER_COUNT    = 2'd1,
        CFG_DEFAULT_DELAY = 2'd2,
        CFG_HEADROOM      = 2'd3
    } cfg_idx_t;

    // result source select
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_NV    = 2'd1,
        RES_READ  = 2'd2,
        RES_QUERY = 2'd3
    } res_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     mem_rd;
        logic     div_start;
        logic     q_step;
        logic     upd_write;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic q_end;
    } sts_t;

endpackage

@@ src/one_way_delay_table_top.sv @@
// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_ready   op, peer, round_trip, peer_mask, now_time
// out       out        out_valid / out_ready value
//
// one word at a time; the steps below run from acceptance to the output register load
// the next word is taken in the idle state after that load, also while a result waits for out_ready
// update: table read, blend sum, then the seven-step shift-and-add divide by ten of the blend
// query: one table read per peer in use, one per cycle through the registered read port
// read: one table read, then the output load; unused codes: a zero word is loaded
// reset clears the written flags at once; no clearing pass. a stalled output holds the word
module one_way_delay_table_top #(
    parameter int MAX_PEERS = owd_pkg::MAX_PEERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [owd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [owd_pkg::OP_W-1:0]          op,
    input  logic [owd_pkg::PEER_W-1:0]        peer,
    input  logic [owd_pkg::DELAY_W-1:0]       round_trip,
    input  logic [owd_pkg::MASK_W-1:0]        peer_mask,
    input  logic [owd_pkg::TIME_W-1:0]        now_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [owd_pkg::VALUE_W-1:0]       value
);

    owd_pkg::cmd_t cmd;
    owd_pkg::sts_t sts;

    // sequencer
    owd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // table, divider and result path
    owd_dpath #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .peer       (peer),
        .round_trip (round_trip),
        .peer_mask  (peer_mask),
        .now_time   (now_time),
        .value      (value),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

@@ src/owd_div10.sv @@
module owd_div10 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [owd_pkg::DIVIDEND_W-1:0]      dividend,
    output logic                                busy,
    output logic [owd_pkg::DELAY_W-1:0]         quotient
);

    localparam logic [2:0] LAST_STEP = 3'd6;
    localparam logic [owd_pkg::DIVIDEND_W-1:0] NINE = owd_pkg::DIVIDEND_W'(9);

    logic                           busy_reg;
    logic [2:0]                     step_reg;
    logic [owd_pkg::DIVIDEND_W-1:0] n_reg;
    logic [owd_pkg::DIVIDEND_W-1:0] q_reg;
    logic [owd_pkg::DIVIDEND_W-1:0] q_next;
    logic [owd_pkg::DIVIDEND_W-1:0] rem;

    // shift-and-add series for 0.8, one add per step, then scale by 1/8 and correct by one
    always_comb
    begin
        rem = n_reg - (q_reg << 3) - (q_reg << 1);
        case (step_reg)
            3'd0:    q_next = (n_reg >> 1) + (n_reg >> 2);
            3'd1:    q_next = q_reg + (q_reg >> 4);
            3'd2:    q_next = q_reg + (q_reg >> 8);
            3'd3:    q_next = q_reg + (q_reg >> 16);
            3'd4:    q_next = q_reg + (q_reg >> 32);
            3'd5:    q_next = q_reg >> 3;
            default: q_next = q_reg + owd_pkg::DIVIDEND_W'(rem > NINE);
        endcase
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend held, quotient estimate refined
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= dividend;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg[owd_pkg::DELAY_W-1:0];

endmodule

@@ src/owd_dpath.sv @@
module owd_dpath #(
    parameter int MAX_PEERS = owd_pkg::MAX_PEERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [owd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [owd_pkg::PEER_W-1:0]        peer,
    input  logic [owd_pkg::DELAY_W-1:0]       round_trip,
    input  logic [owd_pkg::MASK_W-1:0]        peer_mask,
    input  logic [owd_pkg::TIME_W-1:0]        now_time,
    output logic [owd_pkg::VALUE_W-1:0]       value,
    input  owd_pkg::cmd_t                     cmd,
    output owd_pkg::sts_t                     sts
);

    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam logic [owd_pkg::COUNT_W-1:0] MAX_CNT = owd_pkg::COUNT_W'(MAX_PEERS);

    // configuration registers
    logic [owd_pkg::PEER_W-1:0]  local_peer_reg;
    logic [owd_pkg::COUNT_W-1:0] peer_count_reg;
    logic [owd_pkg::DELAY_W-1:0] default_delay_reg;
    logic [owd_pkg::HEAD_W-1:0]  headroom_reg;

    // captured item
    logic [owd_pkg::PEER_W-1:0]  peer_reg;
    logic [owd_pkg::HALF_W-1:0]  half_reg;
    logic [owd_pkg::MASK_W-1:0]  mask_reg;
    logic [owd_pkg::TIME_W-1:0]  now_reg;

    // table
    logic [owd_pkg::DELAY_W-1:0] delay_mem [MAX_PEERS];
    logic [MAX_PEERS-1:0]        present_reg;
    logic [owd_pkg::DELAY_W-1:0] rd_data_reg;
    logic [owd_pkg::PEER_W-1:0]  rd_idx_reg;
    logic                        rd_tap_reg;

    // query walk
    logic [CW-1:0]               q_cnt_reg;
    logic [owd_pkg::DELAY_W-1:0] best_reg;
    logic [owd_pkg::VALUE_W-1:0] value_reg;

    logic [owd_pkg::COUNT_W-1:0] n_use;
    logic                        q_end;
    logic                        q_issue;
    logic [owd_pkg::PEER_W-1:0]  q_idx;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic                        upd_slot_ok;

    logic                        slot_ok;
    logic                        present_bit;
    logic                        below;
    logic                        has_entry;
    logic [owd_pkg::DELAY_W-1:0] eff;

    logic [owd_pkg::DIVIDEND_W-1:0] old_ext;
    logic [owd_pkg::DIVIDEND_W-1:0] half_ext;
    logic [owd_pkg::DIVIDEND_W-1:0] dividend;
    logic                           div_busy;
    logic [owd_pkg::DELAY_W-1:0]    nv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_peer_reg    <= owd_pkg::LOCAL_PEER_RST;
            peer_count_reg    <= owd_pkg::PEER_COUNT_RST;
            default_delay_reg <= owd_pkg::DEFAULT_DELAY_RST;
            headroom_reg      <= owd_pkg::HEADROOM_RST;
        end
        else if (cfg_we)
        begin
            case (owd_pkg::cfg_idx_t'(cfg_index))
                owd_pkg::CFG_LOCAL_PEER:    local_peer_reg    <= cfg_data[owd_pkg::PEER_W-1:0];
                owd_pkg::CFG_PEER_COUNT:    peer_count_reg    <= cfg_data[owd_pkg::COUNT_W-1:0];
                owd_pkg::CFG_DEFAULT_DELAY: default_delay_reg <= cfg_data[owd_pkg::DELAY_W-1:0];
                owd_pkg::CFG_HEADROOM:      headroom_reg      <= cfg_data[owd_pkg::HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            peer_reg <= peer;
            half_reg <= round_trip[owd_pkg::DELAY_W-1:1];
            mask_reg <= peer_mask;
            now_reg  <= now_time;
        end
    end

    // peers in use, clipped to the table depth
    always_comb
    begin
        n_use       = (peer_count_reg > MAX_CNT) ? MAX_CNT : peer_count_reg;
        q_end       = (q_cnt_reg == CW'(n_use));
        q_issue     = cmd.q_step && !q_end;
        q_idx       = owd_pkg::PEER_W'(q_cnt_reg);
        rd_en       = cmd.mem_rd || q_issue;
        rd_addr     = q_issue ? q_idx[IW-1:0] : peer_reg[IW-1:0];
        upd_slot_ok = ({1'b0, peer_reg} < MAX_CNT);
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd_write && upd_slot_ok)
        begin
            delay_mem[peer_reg[IW-1:0]] <= nv;
        end
        if (rd_en)
        begin
            rd_data_reg <= delay_mem[rd_addr];
            rd_idx_reg  <= q_issue ? q_idx : peer_reg;
        end
    end

    // written flags and read tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            rd_tap_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.upd_write && upd_slot_ok)
            begin
                present_reg[peer_reg[IW-1:0]] <= 1'b1;
            end
            rd_tap_reg <= q_issue && mask_reg[q_idx];
        end
    end

    // effective delay of the entry just read
    always_comb
    begin
        slot_ok     = ({1'b0, rd_idx_reg} < MAX_CNT);
        present_bit = present_reg[rd_idx_reg[IW-1:0]];
        below       = ({1'b0, rd_idx_reg} < n_use);
        has_entry   = slot_ok && (present_bit || below);
        if (slot_ok && present_bit)
        begin
            eff = rd_data_reg;
        end
        else if (slot_ok && below && (rd_idx_reg == local_peer_reg))
        begin
            eff = '0;
        end
        else
        begin
            eff = default_delay_reg;
        end
    end

    // blend numerator; a fresh entry passes 10*half so the divide returns half
    always_comb
    begin
        old_ext  = owd_pkg::DIVIDEND_W'(eff);
        half_ext = owd_pkg::DIVIDEND_W'(half_reg);
        if (has_entry)
        begin
            dividend = (old_ext << 3) - old_ext + (half_ext << 1) + half_ext;
        end
        else
        begin
            dividend = (half_ext << 3) + (half_ext << 1);
        end
    end

    owd_div10 u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .busy     (div_busy),
        .quotient (nv)
    );

    // query counter and running maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            best_reg  <= '0;
        end
        else if (cmd.load_in)
        begin
            q_cnt_reg <= '0;
            best_reg  <= '0;
        end
        else
        begin
            if (q_issue)
            begin
                q_cnt_reg <= q_cnt_reg + 1'b1;
            end
            if (rd_tap_reg && (eff > best_reg))
            begin
                best_reg <= eff;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                owd_pkg::RES_NV:    value_reg <= owd_pkg::VALUE_W'(nv);
                owd_pkg::RES_READ:  value_reg <= owd_pkg::VALUE_W'(eff);
                owd_pkg::RES_QUERY: value_reg <= owd_pkg::VALUE_W'(now_reg)
                                               + owd_pkg::VALUE_W'(best_reg)
                                               + owd_pkg::VALUE_W'(headroom_reg);
                default:            value_reg <= '0;
            endcase
        end
    end

    assign value        = value_reg;
    assign sts.div_busy = div_busy;
    assign sts.q_end    = q_end;

endmodule

@@ src/owd_ctrl.sv @@
module owd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [owd_pkg::OP_W-1:0]    op,
    output logic                        out_valid,
    input  logic                        out_ready,
    output owd_pkg::cmd_t               cmd,
    input  owd_pkg::sts_t               sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_RD,
        S_UPD_SUM,
        S_UPD_DIV,
        S_UPD_DONE,
        S_RD_RD,
        S_RD_DONE,
        S_QRY,
        S_Q_DONE,
        S_ZERO_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = owd_pkg::RES_ZERO;
        can_load   = !out_valid_reg || out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    case (owd_pkg::op_t'(op))
                        owd_pkg::OP_UPDATE: state_next = S_UPD_RD;
                        owd_pkg::OP_QUERY:  state_next = S_QRY;
                        owd_pkg::OP_READ:   state_next = S_RD_RD;
                        default:            state_next = S_ZERO_DONE;
                    endcase
                end
            end
            S_UPD_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_UPD_SUM;
            end
            S_UPD_SUM:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_UPD_DIV;
            end
            S_UPD_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_UPD_DONE;
                end
            end
            S_UPD_DONE:
            begin
                cmd.res_sel = owd_pkg::RES_NV;
                if (can_load)
                begin
                    cmd.res_load  = 1'b1;
                    cmd.upd_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RD_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RD_DONE;
            end
            S_RD_DONE:
            begin
                cmd.res_sel = owd_pkg::RES_READ;
                if (can_load)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_QRY:
            begin
                cmd.q_step = 1'b1;
                if (sts.q_end)
                begin
                    state_next = S_Q_DONE;
                end
            end
            S_Q_DONE:
            begin
                cmd.res_sel = owd_pkg::RES_QUERY;
                if (can_load)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ZERO_DONE:
            begin
                cmd.res_sel = owd_pkg::RES_ZERO;
                if (can_load)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output word valid
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ tb/sv/one_way_delay_table_top_tb.sv @@
`timescale 1ns / 1ps

module one_way_delay_table_top_tb;
    import owd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 250;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [PEER_W-1:0]  peer;
        logic [DELAY_W-1:0] round_trip;
        logic [MASK_W-1:0]  peer_mask;
        logic [TIME_W-1:0]  now_time;
    } word_t;

    // scoreboard: own copy of the delay table and the registers
    class delay_scoreboard;
        logic [PEER_W-1:0]  local_idx;
        logic [COUNT_W-1:0] count_reg;
        logic [DELAY_W-1:0] dflt;
        logic [HEAD_W-1:0]  head;
        logic [DELAY_W-1:0] store [MAX_PEERS_DEF];
        bit                 written [MAX_PEERS_DEF];
        logic [VALUE_W-1:0] expected_values [$];
        int                 errors;
        int                 checked;
        int                 settings;
        int                 op_seen [4];

        function new();
            local_idx = LOCAL_PEER_RST;
            count_reg = PEER_COUNT_RST;
            dflt      = DEFAULT_DELAY_RST;
            head      = HEADROOM_RST;
            foreach (written[i])
            begin
                written[i] = 1'b0;
                store[i]   = '0;
            end
            foreach (op_seen[i])
                op_seen[i] = 0;
            errors   = 0;
            checked  = 0;
            settings = 0;
        endfunction

        // register write, only the field width is kept
        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOCAL_PEER:    local_idx = data[PEER_W-1:0];
                CFG_PEER_COUNT:    count_reg = data[COUNT_W-1:0];
                CFG_DEFAULT_DELAY: dflt      = data[DELAY_W-1:0];
                CFG_HEADROOM:      head      = data[HEAD_W-1:0];
                default:           ;
            endcase
        endfunction

        function int unsigned in_use();
            return (count_reg > MAX_PEERS_DEF) ? MAX_PEERS_DEF : count_reg;
        endfunction

        // delay seen for a peer: written entry, else initial delay
        function logic [DELAY_W-1:0] delay_of(int unsigned i);
            if (written[i])
                return store[i];
            if (i < in_use() && i == local_idx)
                return '0;
            return dflt;
        endfunction

        function logic [VALUE_W-1:0] predict_value(word_t w);
            logic [DELAY_W-2:0] half;
            logic [DELAY_W-1:0] nv;
            logic [63:0]        blend;
            logic [63:0]        best;
            logic [63:0]        sum;
            case (w.op)
                OP_UPDATE:
                begin
                    half = w.round_trip[DELAY_W-1:1];
                    nv   = {1'b0, half};
                    // blend only when the peer has a delay to start from
                    if (written[w.peer] || w.peer < in_use())
                    begin
                        blend = (64'd7 * delay_of(w.peer) + 64'd3 * half) / 64'd10;
                        nv    = blend[DELAY_W-1:0];
                    end
                    store[w.peer]   = nv;
                    written[w.peer] = 1'b1;
                    return {17'd0, nv};
                end
                OP_QUERY:
                begin
                    best = '0;
                    for (int i = 0; i < in_use(); i++)
                        if (w.peer_mask[i] && delay_of(i) > best)
                            best = 64'(delay_of(i));
                    sum = 64'(w.now_time) + best + 64'(head);
                    return sum[VALUE_W-1:0];
                end
                OP_READ:
                    return {17'd0, delay_of(w.peer)};
                default:
                    return '0;
            endcase
        endfunction

        function void note_word(word_t w);
            op_seen[w.op]++;
            expected_values = {expected_values, predict_value(w)};
        endfunction

        function void check_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] want;
            checked++;
            if (expected_values.size() == 0)
            begin
                $error("value: unexpected word 0x%0h with nothing outstanding", v);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (v !== want)
            begin
                $error("value: expected 0x%0h, actual 0x%0h", want, v);
                errors++;
            end
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void close();
            if (expected_values.size() != 0)
            begin
                $error("value: %0d words never came out", expected_values.size());
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       op;
    logic [PEER_W-1:0]     peer;
    logic [DELAY_W-1:0]    round_trip;
    logic [MASK_W-1:0]     peer_mask;
    logic [TIME_W-1:0]     now_time;
    logic                  out_valid;
    logic                  out_ready;
    logic [VALUE_W-1:0]    value;

    delay_scoreboard book;
    int              send_left = 0;
    bit              send_calm = 1'b0;
    int              cycle_count = 0;

    one_way_delay_table_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .peer       (peer),
        .round_trip (round_trip),
        .peer_mask  (peer_mask),
        .now_time   (now_time),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("one_way_delay_table_top verification failed");
            $finish;
        end
    end

    // sender gap, with stretches of back-to-back words
    function automatic int send_gap();
        if (send_left == 0)
        begin
            send_left = 40;
            send_calm = ($urandom_range(0, 3) == 0);
        end
        send_left--;
        return send_calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] o, input logic [PEER_W-1:0] p,
                             input logic [DELAY_W-1:0] rtt, input logic [MASK_W-1:0] m,
                             input logic [TIME_W-1:0] t);
        word_t w;
        int    gap;
        w.op         = o;
        w.peer       = p;
        w.round_trip = rtt;
        w.peer_mask  = m;
        w.now_time   = t;
        gap = send_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        peer       <= p;
        round_trip <= rtt;
        peer_mask  <= m;
        now_time   <= t;
        do @(posedge clk); while (in_ready !== 1'b1);
        book.note_word(w);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] lp, input logic [CFG_DATA_W-1:0] cnt,
                             input logic [CFG_DATA_W-1:0] dd, input logic [CFG_DATA_W-1:0] hr);
        write_reg(CFG_LOCAL_PEER, lp);
        write_reg(CFG_PEER_COUNT, cnt);
        write_reg(CFG_DEFAULT_DELAY, dd);
        write_reg(CFG_HEADROOM, hr);
        book.settings++;
    endtask

    // stop offering and wait until every word is back
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one setting of the registers, then a stream of random words
    task automatic random_phase(input int k);
        logic [CFG_DATA_W-1:0] cnt;
        logic [CFG_DATA_W-1:0] dd;
        logic [OP_W-1:0]       o;
        logic [PEER_W-1:0]     p;
        logic [DELAY_W-1:0]    rtt;
        logic [MASK_W-1:0]     m;
        logic [TIME_W-1:0]     t;
        int                    sel;
        int unsigned           lim;
        if (k == 0)
            configure(32'd63, 32'd127, 32'hFFFF_FFFF, 32'h0000_FFFF);
        else if (k == 1)
            configure('0, '0, '0, '0);
        else
        begin
            case ($urandom_range(0, 5))
                0:       cnt = 32'd0;
                1:       cnt = 32'd1;
                2:       cnt = 32'd64;
                3:       cnt = $urandom_range(65, 127);
                default: cnt = $urandom_range(2, 63);
            endcase
            case ($urandom_range(0, 3))
                0:       dd = '0;
                1:       dd = 32'hFFFF_FFFF;
                2:       dd = $urandom_range(0, 1000);
                default: dd = $urandom;
            endcase
            // junk above the field widths must be dropped
            configure($urandom, ($urandom & ~32'h7F) | cnt, dd, $urandom);
        end
        lim = book.in_use();
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            sel = $urandom_range(0, 19);
            if (sel < 8)
                o = OP_UPDATE;
            else if (sel < 14)
                o = OP_QUERY;
            else if (sel < 19)
                o = OP_READ;
            else
                o = OP_UNUSED;
            // mostly peers in use, so entries get revisited
            if (lim == 0 || $urandom_range(0, 3) == 0)
                p = PEER_W'($urandom);
            else
                p = PEER_W'($urandom_range(0, lim - 1));
            case ($urandom_range(0, 5))
                0:       rtt = '0;
                1:       rtt = '1;
                2:       rtt = $urandom_range(0, 400);
                default: rtt = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       m = '0;
                1:       m = '1;
                2:       m = 64'd1 << $urandom_range(0, 63);
                default: m = {$urandom, $urandom};
            endcase
            if ($urandom_range(0, 7) == 0)
                t = '1;
            else
                t = TIME_W'({$urandom, $urandom});
            send_word(o, p, rtt, m, t);
        end
        settle();
    endtask

    // result side: random stalls, one long hold-off to back up the block
    initial
    begin : result_sink
        int gap;
        int left;
        bit calm;
        bit held;
        left = 0;
        calm = 1'b0;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && book.checked >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    left = 50;
                    calm = ($urandom_range(0, 3) == 0);
                end
                left--;
                gap = calm ? 0 : $urandom_range(0, 13);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            book.check_value(value);
        end
    end

    initial
    begin
        book = new();
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_LOCAL_PEER;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        op         <= OP_UPDATE;
        peer       <= '0;
        round_trip <= '0;
        peer_mask  <= '0;
        now_time   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: local peer 0, one peer in use
        send_word(OP_READ, 6'd0, '0, '0, '0);
        send_word(OP_READ, 6'd5, '0, '0, '0);
        send_word(OP_QUERY, '0, '0, '1, '0);
        send_word(OP_UPDATE, 6'd0, 32'd100, '0, '0);
        // first update beyond the peer count stores half the round trip, unblended
        send_word(OP_UPDATE, 6'd63, '1, '0, '0);
        send_word(OP_UPDATE, 6'd63, '1, '0, '0);
        send_word(OP_READ, 6'd63, '0, '0, '0);
        send_word(OP_UNUSED, 6'h2A, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5555);
        send_word(OP_QUERY, '0, '0, '1, '1);
        settle();

        // all registers at their top, but the peer count at the table depth
        configure(32'd63, 32'd64, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_word(OP_QUERY, '0, '0, '1, '1);
        send_word(OP_UPDATE, 6'd1, '0, '0, '0);
        send_word(OP_UPDATE, 6'd62, 32'd1, '0, '0);
        send_word(OP_READ, 6'd62, '0, '0, '0);
        send_word(OP_QUERY, '0, '0, '0, '1);
        send_word(OP_QUERY, '0, '0, 64'h8000_0000_0000_0000, 48'd1);
        settle();

        // no peers in use
        configure('0, '0, '0, '0);
        send_word(OP_QUERY, '0, '0, '1, 48'd12345);
        send_word(OP_UPDATE, 6'd10, 32'd1000, '0, '0);
        send_word(OP_READ, 6'd10, '0, '0, '0);
        send_word(OP_READ, 6'd20, '0, '0, '0);
        settle();

        // count above the table size, unwritten entries follow it
        configure(32'd5, 32'd127, 32'd1000, 32'd7);
        send_word(OP_QUERY, '0, '0, '1, '0);
        send_word(OP_READ, 6'd5, '0, '0, '0);
        send_word(OP_UPDATE, 6'd5, 32'd3, '0, '0);
        send_word(OP_UNUSED, '1, '1, '1, '1);
        settle();

        for (int k = 0; k < PHASES; k++)
            random_phase(k);

        repeat (70) @(posedge clk);
        book.close();
        $display("covered %0d updates, %0d queries, %0d reads, %0d unused-code words",
                 book.op_seen[OP_UPDATE], book.op_seen[OP_QUERY], book.op_seen[OP_READ],
                 book.op_seen[OP_UNUSED]);
        $display("%0d register settings, %0d words compared, %0d mismatches",
                 book.settings, book.checked, book.errors);
        if (book.errors == 0)
            $display("one_way_delay_table_top verification clean");
        else
            $display("one_way_delay_table_top verification failed");
        $finish;
    end

endmodule
